@@ hw/rtl/rmq_pkg.sv @@
// Shared types and defaults for the rotation matrix to quaternion unit.
package rmq_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int NUM_LANES      = 4;
   localparam int NUM_ENTRIES    = 9;

   typedef enum logic [1:0] {
      LANE_W = 2'd0,
      LANE_X = 2'd1,
      LANE_Y = 2'd2,
      LANE_Z = 2'd3
   } lane_type;

   typedef struct packed {
      logic                 valid;
      logic                 degenerate;
      logic [NUM_LANES-1:0] neg;
   } rmq_tag_type;

endpackage

@@ hw/rtl/rmq_front.sv @@
// Front cell: clamped candidates, their total, the signs and the integer quotient bit.
module rmq_front #(
   parameter int DW = 16,
   parameter int F  = 14,
   parameter int RW = 20,
   parameter int QW = 29
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                valid_in,
   input  logic [9*DW-1:0]     entries,
   output logic [RW-1:0]       rem_out   [4],
   output logic [QW-1:0]       quot_out  [4],
   output logic [RW-1:0]       total_out,
   output rmq_pkg::rmq_tag_type tag_out
);
   import rmq_pkg::*;

   localparam int CW = RW - 1;

   logic signed [DW-1:0]   m [NUM_ENTRIES];
   logic signed [CW-1:0]   e11, e22, e33, one_s;
   logic signed [CW-1:0]   cand [NUM_LANES];
   logic [CW-2:0]          cl [NUM_LANES];
   logic [RW-1:0]          total;
   logic [CW-2:0]          big_v;
   lane_type               big;
   logic signed [DW:0]     d_32m23, d_13m31, d_21m12, s_21p12, s_13p31, s_32p23;
   logic [NUM_LANES-1:0]   neg;
   logic [RW-1:0]          rem_in   [NUM_LANES];
   logic [QW-1:0]          quot_in  [NUM_LANES];
   logic [RW-1:0]          rem_ff   [NUM_LANES];
   logic [QW-1:0]          quot_ff  [NUM_LANES];
   logic [RW-1:0]          total_ff;
   rmq_tag_type            tag_in, tag_ff;

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         m[i] = entries[i*DW +: DW];
      end
      e11   = {{(CW-DW){m[0][DW-1]}}, m[0]};
      e22   = {{(CW-DW){m[4][DW-1]}}, m[4]};
      e33   = {{(CW-DW){m[8][DW-1]}}, m[8]};
      one_s = {{(CW-1){1'b0}}, 1'b1} << F;
      cand[0] =  e11 + e22 + e33 + one_s;
      cand[1] =  e11 - e22 - e33 + one_s;
      cand[2] = -e11 + e22 - e33 + one_s;
      cand[3] = -e11 - e22 + e33 + one_s;
      total = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         cl[i] = cand[i][CW-1] ? '0 : cand[i][CW-2:0];
         total = total + {2'b00, cl[i]};
      end
      big_v = cl[0];
      big   = LANE_W;
      for (int i = 1; i < NUM_LANES; i++) begin
         if (cl[i] > big_v) begin
            big_v = cl[i];
            big   = lane_type'(i);
         end
      end
      d_32m23 = {m[7][DW-1], m[7]} - {m[5][DW-1], m[5]};
      d_13m31 = {m[2][DW-1], m[2]} - {m[6][DW-1], m[6]};
      d_21m12 = {m[3][DW-1], m[3]} - {m[1][DW-1], m[1]};
      s_21p12 = {m[3][DW-1], m[3]} + {m[1][DW-1], m[1]};
      s_13p31 = {m[2][DW-1], m[2]} + {m[6][DW-1], m[6]};
      s_32p23 = {m[7][DW-1], m[7]} + {m[5][DW-1], m[5]};
      neg = '0;
      case (big)
         LANE_W: begin
            neg[1] = d_32m23[DW];
            neg[2] = d_13m31[DW];
            neg[3] = d_21m12[DW];
         end
         LANE_X: begin
            neg[0] = d_32m23[DW];
            neg[2] = s_21p12[DW];
            neg[3] = s_13p31[DW];
         end
         LANE_Y: begin
            neg[0] = d_13m31[DW];
            neg[1] = s_21p12[DW];
            neg[3] = s_32p23[DW];
         end
         LANE_Z: begin
            neg[0] = d_21m12[DW];
            neg[1] = s_13p31[DW];
            neg[2] = s_32p23[DW];
         end
         default: begin
            neg = '0;
         end
      endcase
      for (int i = 0; i < NUM_LANES; i++) begin
         if ({2'b00, cl[i]} == total) begin
            rem_in[i]  = '0;
            quot_in[i] = {{(QW-1){1'b0}}, 1'b1};
         end else begin
            rem_in[i]  = {2'b00, cl[i]};
            quot_in[i] = '0;
         end
      end
      tag_in.valid      = valid_in;
      tag_in.degenerate = (total == '0);
      tag_in.neg        = neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (enable) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
         total_ff <= total;
      end
   end

   assign rem_out   = rem_ff;
   assign quot_out  = quot_ff;
   assign total_out = total_ff;
   assign tag_out   = tag_ff;

endmodule

@@ hw/rtl/rmq_div_cell.sv @@
// Division cell: one quotient bit of the normalised ratio for each of the four lanes.
module rmq_div_cell #(
   parameter int RW = 20,
   parameter int QW = 29
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic [RW-1:0]        rem_i   [4],
   input  logic [QW-1:0]        quot_i  [4],
   input  logic [RW-1:0]        total_i,
   input  rmq_pkg::rmq_tag_type tag_i,
   output logic [RW-1:0]        rem_o   [4],
   output logic [QW-1:0]        quot_o  [4],
   output logic [RW-1:0]        total_o,
   output rmq_pkg::rmq_tag_type tag_o
);
   import rmq_pkg::*;

   logic [RW:0]   shifted [NUM_LANES];
   logic [RW:0]   diff    [NUM_LANES];
   logic [RW-1:0] rem_in  [NUM_LANES];
   logic [QW-1:0] quot_in [NUM_LANES];
   logic [RW-1:0] rem_ff  [NUM_LANES];
   logic [QW-1:0] quot_ff [NUM_LANES];
   logic [RW-1:0] total_ff;
   rmq_tag_type   tag_ff;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         shifted[i] = {rem_i[i], 1'b0};
         diff[i]    = shifted[i] - {1'b0, total_i};
         if (shifted[i] >= {1'b0, total_i}) begin
            rem_in[i]  = diff[i][RW-1:0];
            quot_in[i] = {quot_i[i][QW-2:0], 1'b1};
         end else begin
            rem_in[i]  = shifted[i][RW-1:0];
            quot_in[i] = {quot_i[i][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (enable) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
         total_ff <= total_i;
      end
   end

   assign rem_o   = rem_ff;
   assign quot_o  = quot_ff;
   assign total_o = total_ff;
   assign tag_o   = tag_ff;

endmodule

@@ hw/rtl/rmq_sqrt_cell.sv @@
// Square-root cell: one root bit for each of the four lanes.
module rmq_sqrt_cell #(
   parameter int F = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic [2*F+1:0]       rad_i  [4],
   input  logic [F:0]           root_i [4],
   input  logic [F+3:0]         rem_i  [4],
   input  rmq_pkg::rmq_tag_type tag_i,
   output logic [2*F+1:0]       rad_o  [4],
   output logic [F:0]           root_o [4],
   output logic [F+3:0]         rem_o  [4],
   output rmq_pkg::rmq_tag_type tag_o
);
   import rmq_pkg::*;

   logic [F+3:0]   rem2    [NUM_LANES];
   logic [F+3:0]   trial   [NUM_LANES];
   logic [2*F+1:0] rad_in  [NUM_LANES];
   logic [F:0]     root_in [NUM_LANES];
   logic [F+3:0]   rem_in  [NUM_LANES];
   logic [2*F+1:0] rad_ff  [NUM_LANES];
   logic [F:0]     root_ff [NUM_LANES];
   logic [F+3:0]   rem_ff  [NUM_LANES];
   rmq_tag_type    tag_ff;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         rem2[i]   = {1'b0, rem_i[i][F:0], rad_i[i][2*F+1:2*F]};
         trial[i]  = {1'b0, root_i[i], 2'b01};
         rad_in[i] = {rad_i[i][2*F-1:0], 2'b00};
         if (rem2[i] >= trial[i]) begin
            rem_in[i]  = rem2[i] - trial[i];
            root_in[i] = {root_i[i][F-1:0], 1'b1};
         end else begin
            rem_in[i]  = rem2[i];
            root_in[i] = {root_i[i][F-1:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (enable) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign rad_o  = rad_ff;
   assign root_o = root_ff;
   assign rem_o  = rem_ff;
   assign tag_o  = tag_ff;

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion_unit.sv @@
// Top level of the rotation matrix to quaternion unit.
//
//  Channel | Direction | Content
//  req     | in        | tdata: m11 m12 m13 m21 m22 m23 m31 m32 m33
//  rsp     | out       | tdata: quat_w quat_x quat_y quat_z, tuser: degenerate
//
// One transfer is accepted in every cycle in which the row is not stalled: the row of
// division and square-root cells moves as one pipeline. Reset clears only the tag registers
// of the cells. When a result is held on rsp, the whole row stalls and req_tready falls.
module rotation_matrix_to_quaternion_unit #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: m11 m12 m13 m21 m22 m23 m31 m32 m33.
   input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0: quat_w quat_x quat_y quat_z.
   output logic [((4*DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   // Fields from bit 0: degenerate.
   output logic                                  rsp_tuser
);
   import rmq_pkg::*;

   localparam int DW   = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int CW   = ((DW > F) ? DW : F) + 3;
   localparam int RW   = CW + 1;
   localparam int QW   = 2 * F + 1;
   localparam int NDIV = 2 * F;
   localparam int NSQ  = F + 1;
   localparam int MW   = ((DW > F + 1) ? DW : F + 1) + 1;
   localparam int OW   = ((4 * DW + 7) / 8) * 8;

   logic             advance;
   logic [RW-1:0]    d_rem   [NDIV+1][4];
   logic [QW-1:0]    d_quot  [NDIV+1][4];
   logic [RW-1:0]    d_total [NDIV+1];
   rmq_tag_type      d_tag   [NDIV+1];
   logic [2*F+1:0]   s_rad   [NSQ+1][4];
   logic [F:0]       s_root  [NSQ+1][4];
   logic [F+3:0]     s_rem   [NSQ+1][4];
   rmq_tag_type      s_tag   [NSQ+1];
   logic [MW-1:0]    mag     [4];
   logic [MW-1:0]    sval    [4];
   logic [4*DW-1:0]  quat;

   assign advance    = !s_tag[NSQ].valid || rsp_tready;
   assign req_tready = advance;

   rmq_front #(.DW(DW), .F(F), .RW(RW), .QW(QW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (req_tvalid),
      .entries   (req_tdata[9*DW-1:0]),
      .rem_out   (d_rem[0]),
      .quot_out  (d_quot[0]),
      .total_out (d_total[0]),
      .tag_out   (d_tag[0])
   );

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      rmq_div_cell #(.RW(RW), .QW(QW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (advance),
         .rem_i   (d_rem[k]),
         .quot_i  (d_quot[k]),
         .total_i (d_total[k]),
         .tag_i   (d_tag[k]),
         .rem_o   (d_rem[k+1]),
         .quot_o  (d_quot[k+1]),
         .total_o (d_total[k+1]),
         .tag_o   (d_tag[k+1])
      );
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_seed
      assign s_rad[0][i]  = {1'b0, d_quot[NDIV][i]};
      assign s_root[0][i] = '0;
      assign s_rem[0][i]  = '0;
   end
   assign s_tag[0] = d_tag[NDIV];

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      rmq_sqrt_cell #(.F(F)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .rad_i  (s_rad[k]),
         .root_i (s_root[k]),
         .rem_i  (s_rem[k]),
         .tag_i  (s_tag[k]),
         .rad_o  (s_rad[k+1]),
         .root_o (s_root[k+1]),
         .rem_o  (s_rem[k+1]),
         .tag_o  (s_tag[k+1])
      );
   end

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         mag[i]  = {{(MW-F-1){1'b0}}, s_root[NSQ][i]};
         sval[i] = s_tag[NSQ].neg[i] ? (MW'(0) - mag[i]) : mag[i];
         if (s_tag[NSQ].degenerate) begin
            quat[i*DW +: DW] = '0;
         end else begin
            quat[i*DW +: DW] = sval[i][DW-1:0];
         end
      end
   end

   assign rsp_tvalid = s_tag[NSQ].valid;
   assign rsp_tdata  = OW'(quat);
   assign rsp_tuser  = s_tag[NSQ].degenerate;

endmodule
